// File: src/ppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_pkg
// Shared constants and width functions for the point/plane distance block.
// ----------------------------------------------------------------------------
package ppd_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int COORD_FRAC     = 8;
    localparam int DIST_BITS      = 32;
    localparam int NUM_COORDS     = 12;
    // |s| is scaled by 2^(16-frac), so its square by twice that
    localparam int SQ_SHIFT       = 2 * (16 - COORD_FRAC);

    // edge vector / offset width
    function automatic int uw_f(input int cb);
        return cb + 1;
    endfunction

    // normal component width
    function automatic int nw_f(input int cb);
        return 2 * uw_f(cb) + 1;
    endfunction

    // plane value width
    function automatic int sw_f(input int cb);
        return nw_f(cb) + uw_f(cb) + 2;
    endfunction

    // squared normal length width
    function automatic int n2w_f(input int cb);
        return 2 * nw_f(cb) + 2;
    endfunction

    // root chain working width: holds the target and every trial value
    function automatic int cw_f(input int cb);
        int tw;
        int pw;
        tw = 2 * sw_f(cb) + SQ_SHIFT;
        pw = n2w_f(cb) + 2 * DIST_BITS + 2;
        return ((tw > pw) ? tw : pw) + 1;
    endfunction

endpackage

// File: src/ppd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_front
// Eight-stage pipeline: edge vectors, normal, plane value, squared normal
// length and the squared scaled plane value used by the root chain.
// ----------------------------------------------------------------------------
module ppd_front #(
    parameter int COORD_BITS = ppd_pkg::COORD_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [ppd_pkg::NUM_COORDS*COORD_BITS-1:0] in_data,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_on,
    output logic [ppd_pkg::n2w_f(COORD_BITS)-1:0] out_n2,
    output logic [ppd_pkg::cw_f(COORD_BITS)-1:0]  out_target
);
    import ppd_pkg::*;

    localparam int CB   = COORD_BITS;
    localparam int UW   = uw_f(CB);
    localparam int PW   = 2 * UW;
    localparam int NW   = nw_f(CB);
    localparam int MW   = NW + UW;
    localparam int QW   = 2 * NW;
    localparam int SW   = sw_f(CB);
    localparam int N2W  = n2w_f(CB);
    localparam int HW   = (SW + 1) / 2;
    localparam int LW   = SW - HW;
    localparam int CW   = cw_f(CB);
    localparam int NST  = 8;

    logic [NST-1:0] vld_reg;
    logic [NST:0]   rdy;

    logic signed [UW-1:0] crd [NUM_COORDS];
    logic signed [UW-1:0] u_reg [3];
    logic signed [UW-1:0] v_reg [3];
    logic signed [UW-1:0] w1_reg [3];
    logic signed [PW-1:0] p_reg [6];
    logic signed [UW-1:0] w2_reg [3];
    logic signed [NW-1:0] n_reg [3];
    logic signed [UW-1:0] w3_reg [3];
    logic signed [MW-1:0] m_reg [3];
    logic signed [QW-1:0] q_reg [3];
    logic signed [SW-1:0] s_reg;
    logic signed [N2W-1:0] n2a_reg;
    logic                 zero5_reg;
    logic [SW-1:0]        abs_reg;
    logic [N2W-1:0]       n2b_reg;
    logic                 zero6_reg;
    logic [2*LW-1:0]      hh_reg;
    logic [LW+HW-1:0]     hl_reg;
    logic [2*HW-1:0]      ll_reg;
    logic [N2W-1:0]       n2c_reg;
    logic                 zero7_reg;
    logic [CW-1:0]        tgt_reg;
    logic [N2W-1:0]       n2d_reg;

    // sign-extend each coordinate by one bit
    always_comb
    begin
        for (int i = 0; i < NUM_COORDS; i++)
        begin
            crd[i] = $signed({in_data[i*CB+CB-1], in_data[i*CB +: CB]});
        end
    end

    // stage advances when empty or when the next one advances
    always_comb
    begin
        rdy[NST] = out_ready;
        for (int i = NST - 1; i >= 0; i--)
        begin
            rdy[i] = !vld_reg[i] || rdy[i+1];
        end
    end

    assign in_ready = rdy[0];

    // hold valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg[0] <= rdy[0] ? in_valid : vld_reg[0];
            for (int i = 1; i < NST; i++)
            begin
                if (rdy[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        // edge vectors u = a - b, v = c - b, offset w = q - a
        if (rdy[0] && in_valid)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i]  <= crd[i] - crd[3+i];
                v_reg[i]  <= crd[6+i] - crd[3+i];
                w1_reg[i] <= crd[9+i] - crd[i];
            end
        end
        // cross product terms
        if (rdy[1] && vld_reg[0])
        begin
            p_reg[0] <= u_reg[1] * v_reg[2];
            p_reg[1] <= v_reg[1] * u_reg[2];
            p_reg[2] <= v_reg[0] * u_reg[2];
            p_reg[3] <= v_reg[2] * u_reg[0];
            p_reg[4] <= u_reg[0] * v_reg[1];
            p_reg[5] <= v_reg[0] * u_reg[1];
            w2_reg   <= w1_reg;
        end
        // normal
        if (rdy[2] && vld_reg[1])
        begin
            for (int i = 0; i < 3; i++)
            begin
                n_reg[i] <= p_reg[2*i] - p_reg[2*i+1];
            end
            w3_reg <= w2_reg;
        end
        // dot terms and squared normal terms
        if (rdy[3] && vld_reg[2])
        begin
            for (int i = 0; i < 3; i++)
            begin
                m_reg[i] <= n_reg[i] * w3_reg[i];
                q_reg[i] <= n_reg[i] * n_reg[i];
            end
        end
        // plane value and squared normal length
        if (rdy[4] && vld_reg[3])
        begin
            s_reg   <= m_reg[0] + m_reg[1] + m_reg[2];
            n2a_reg <= q_reg[0] + q_reg[1] + q_reg[2];
        end
        // magnitude of the plane value
        if (rdy[5] && vld_reg[4])
        begin
            zero5_reg <= (s_reg == '0);
            abs_reg   <= s_reg[SW-1] ? (-s_reg) : s_reg;
            n2b_reg   <= n2a_reg;
        end
        // partial products of |s| squared
        if (rdy[6] && vld_reg[5])
        begin
            hh_reg    <= abs_reg[SW-1:HW] * abs_reg[SW-1:HW];
            hl_reg    <= abs_reg[SW-1:HW] * abs_reg[HW-1:0];
            ll_reg    <= abs_reg[HW-1:0] * abs_reg[HW-1:0];
            zero6_reg <= zero5_reg;
            n2c_reg   <= n2b_reg;
        end
        // combine into the scaled square
        if (rdy[7] && vld_reg[6])
        begin
            tgt_reg <= ((CW'(hh_reg) << (2 * HW)) + (CW'(hl_reg) << (HW + 1))
                        + CW'(ll_reg)) << SQ_SHIFT;
            zero7_reg <= zero6_reg;
            n2d_reg   <= n2c_reg;
        end
    end

    assign out_valid  = vld_reg[NST-1];
    assign out_on     = zero7_reg;
    assign out_n2     = n2d_reg;
    assign out_target = tgt_reg;

endmodule

// File: src/ppd_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_cell
// One digit of the restoring square root search: decides distance bit K
// from the running remainder and the running product distance * n2.
// ----------------------------------------------------------------------------
module ppd_cell #(
    parameter int COORD_BITS = ppd_pkg::COORD_BITS_DEF,
    parameter int K          = 0
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  in_on,
    input  logic [ppd_pkg::n2w_f(COORD_BITS)-1:0] in_n2,
    input  logic [ppd_pkg::cw_f(COORD_BITS)-1:0]  in_rem,
    input  logic [ppd_pkg::cw_f(COORD_BITS)-1:0]  in_prod,
    input  logic [ppd_pkg::DIST_BITS-1:0]         in_dist,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic                                  out_on,
    output logic [ppd_pkg::n2w_f(COORD_BITS)-1:0] out_n2,
    output logic [ppd_pkg::cw_f(COORD_BITS)-1:0]  out_rem,
    output logic [ppd_pkg::cw_f(COORD_BITS)-1:0]  out_prod,
    output logic [ppd_pkg::DIST_BITS-1:0]         out_dist
);
    import ppd_pkg::*;

    localparam int CW = cw_f(COORD_BITS);

    logic          vld_reg;
    logic          on_reg;
    logic [n2w_f(COORD_BITS)-1:0] n2_reg;
    logic [CW-1:0] rem_reg;
    logic [CW-1:0] prod_reg;
    logic [DIST_BITS-1:0] dist_reg;
    logic [CW-1:0] n2_wide;
    logic [CW-1:0] trial;
    logic          fits;

    // (D + 2^K)^2 n2 - D^2 n2 = 2^(K+1) D n2 + 2^(2K) n2
    assign n2_wide  = CW'(in_n2);
    assign trial    = (in_prod << (K + 1)) + (n2_wide << (2 * K));
    assign fits     = (trial <= in_rem);
    assign in_ready = !vld_reg || out_ready;

    // hold valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            vld_reg <= in_valid;
        end
    end

    // advance remainder, product and distance
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            on_reg   <= in_on;
            n2_reg   <= in_n2;
            rem_reg  <= fits ? (in_rem - trial) : in_rem;
            prod_reg <= fits ? (in_prod + (n2_wide << K)) : in_prod;
            dist_reg <= fits ? (in_dist | (DIST_BITS'(1) << K)) : in_dist;
        end
    end

    assign out_valid = vld_reg;
    assign out_on    = on_reg;
    assign out_n2    = n2_reg;
    assign out_rem   = rem_reg;
    assign out_prod  = prod_reg;
    assign out_dist  = dist_reg;

endmodule

// File: src/point_plane_distance.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_plane_distance
// Distance of a query point from the plane through three points.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one request per cycle unless stalled: three
//   plane points and a query point, twelve signed coordinates packed in
//   s_tdata. The master channel returns one result per request, in order:
//   the distance as unsigned Q16.16 in m_tdata (saturated at all ones) and
//   the on-plane flag in m_tuser. On-plane requests, including collinear
//   triples, give zero. Its 8 arithmetic stages (edge vectors, normal, dot
//   product, squares) feed a chain of 32 root cells, one per distance bit.
//   Every stage owns its own valid bit. When the receiver stalls, the result
//   holds in the last cell and the stall moves back only through stages
//   that are full, so empty stages keep taking requests. Reset clears all
//   valid bits; no request is lost or repeated.
// ----------------------------------------------------------------------------
module point_plane_distance #(
    parameter int COORD_BITS = ppd_pkg::COORD_BITS_DEF,
    localparam int IN_W = ((ppd_pkg::NUM_COORDS * COORD_BITS + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, query_x, query_y, query_z
    input  logic [IN_W-1:0]               s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // distance
    output logic [ppd_pkg::DIST_BITS-1:0] m_tdata,
    // on_plane
    output logic                          m_tuser
);
    import ppd_pkg::*;

    localparam int N2W  = n2w_f(COORD_BITS);
    localparam int CW   = cw_f(COORD_BITS);
    localparam int FW   = NUM_COORDS * COORD_BITS;

    logic                 cv [DIST_BITS+1];
    logic                 cr [DIST_BITS+1];
    logic                 con [DIST_BITS+1];
    logic [N2W-1:0]       cn2 [DIST_BITS+1];
    logic [CW-1:0]        crem [DIST_BITS+1];
    logic [CW-1:0]        cprod [DIST_BITS+1];
    logic [DIST_BITS-1:0] cdist [DIST_BITS+1];

    // arithmetic front end
    ppd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_data    (s_tdata[FW-1:0]),
        .out_valid  (cv[0]),
        .out_ready  (cr[0]),
        .out_on     (con[0]),
        .out_n2     (cn2[0]),
        .out_target (crem[0])
    );

    assign cprod[0] = '0;
    assign cdist[0] = '0;

    // root chain, most significant bit first
    for (genvar j = 0; j < DIST_BITS; j++)
    begin : g_cell
        ppd_cell #(
            .COORD_BITS (COORD_BITS),
            .K          (DIST_BITS - 1 - j)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (cv[j]),
            .in_ready  (cr[j]),
            .in_on     (con[j]),
            .in_n2     (cn2[j]),
            .in_rem    (crem[j]),
            .in_prod   (cprod[j]),
            .in_dist   (cdist[j]),
            .out_valid (cv[j+1]),
            .out_ready (cr[j+1]),
            .out_on    (con[j+1]),
            .out_n2    (cn2[j+1]),
            .out_rem   (crem[j+1]),
            .out_prod  (cprod[j+1]),
            .out_dist  (cdist[j+1])
        );
    end

    // drive the result; on-plane forces zero distance
    assign cr[DIST_BITS] = m_tready;
    assign m_tvalid      = cv[DIST_BITS];
    assign m_tuser       = con[DIST_BITS];
    assign m_tdata       = con[DIST_BITS] ? '0 : cdist[DIST_BITS];

endmodule
